FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Types and constants of the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int MAP_BYTES = 512;
   localparam int WORD_BITS = 64;
   localparam int BITPOS_W  = 6;
   localparam int MAP_WORDS = 64;
   localparam int WADDR_W   = 6;
   localparam int WCNT_W    = 7;
   localparam int UNIT_W    = 12;
   localparam int LEN_W     = 13;
   localparam int BYTES_W   = 10;

   localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(MAP_BYTES);

   localparam logic [2:0] FUNC_TEST      = 3'd0;
   localparam logic [2:0] FUNC_SET       = 3'd1;
   localparam logic [2:0] FUNC_CLEAR     = 3'd2;
   localparam logic [2:0] FUNC_SCAN      = 3'd3;
   localparam logic [2:0] FUNC_CLEAR_ALL = 3'd4;

   typedef struct packed {
      logic [2:0]        func;
      logic [UNIT_W-1:0] bit_index;
      logic [LEN_W-1:0]  run_length;
   } req_type;

   typedef struct packed {
      logic              flag;
      logic [UNIT_W-1:0] start_index;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One masked map word handed to the scan unit (1 = unit not available).
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [WADDR_W-1:0]   idx;
      logic [WORD_BITS-1:0] used;
   } scan_in_type;

   typedef struct packed {
      logic              done;
      logic              hit;
      logic [UNIT_W-1:0] start;
   } scan_res_type;

   // Nearest used bit at or below a position within the word.
   typedef struct packed {
      logic                found;
      logic [BITPOS_W-1:0] pos;
   } last_used_type;

endpackage

FILE: rtl/core/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bra_scan_unit.sv
// ----------------------------------------------------------------------------
// bra_scan_unit
// Two-stage word scanner: finds the first position at which a free run
// reaches the requested length, carrying the open run across words.
// ----------------------------------------------------------------------------
module bra_scan_unit import bra_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  scan_in_type      word_in,
   input  logic [LEN_W-1:0] need,
   output scan_res_type     result
);

   last_used_type            lu_lvl [BITPOS_W+1][WORD_BITS];
   last_used_type            lu_ff  [WORD_BITS];
   logic                     s1_vld_ff;
   logic                     s1_last_ff;
   logic [WADDR_W-1:0]       s1_idx_ff;
   logic [LEN_W-1:0]         carry_ff;
   logic [LEN_W-1:0]         carry_in;
   logic [LEN_W-1:0]         runlen [WORD_BITS];
   logic [WORD_BITS-1:0]     hit_vec;
   logic                     hit_any;
   logic [BITPOS_W-1:0]      hit_pos;

   // Stage 1: prefix search for the nearest used bit at or below each position.
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         lu_lvl[0][p].found = word_in.used[p];
         lu_lvl[0][p].pos   = BITPOS_W'(p);
      end
      for (int l = 0; l < BITPOS_W; l++) begin
         for (int p = 0; p < WORD_BITS; p++) begin
            if (!lu_lvl[l][p].found && p >= (1 << l)) begin
               lu_lvl[l+1][p] = lu_lvl[l][p - (1 << l)];
            end else begin
               lu_lvl[l+1][p] = lu_lvl[l][p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= word_in.valid;
      end
      s1_last_ff <= word_in.last;
      s1_idx_ff  <= word_in.idx;
      for (int p = 0; p < WORD_BITS; p++) begin
         lu_ff[p] <= lu_lvl[BITPOS_W][p];
      end
   end

   // Stage 2: run length ending at each position, first one that is long enough.
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         if (lu_ff[p].found) begin
            runlen[p] = LEN_W'(p) - LEN_W'(lu_ff[p].pos);
         end else begin
            runlen[p] = LEN_W'(p) + LEN_W'(1) + carry_ff;
         end
         hit_vec[p] = (runlen[p] >= need);
      end
      hit_any = s1_vld_ff && (hit_vec != '0);
      hit_pos = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (hit_vec[p]) begin
            hit_pos = BITPOS_W'(p);
         end
      end
      carry_in = runlen[WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         carry_ff <= '0;
      end else if (s1_vld_ff) begin
         carry_ff <= carry_in;
      end
   end

   assign result.done  = s1_vld_ff && (hit_any || s1_last_ff);
   assign result.hit   = hit_any;
   assign result.start = {s1_idx_ff, BITPOS_W'(0)} + UNIT_W'(hit_pos) + UNIT_W'(1)
                         - need[UNIT_W-1:0];

endmodule

FILE: rtl/core/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// Allocation bitmap of 4096 units with bit test/set/clear, clear-all and a
// first-fit search for a run of free units.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Content
//  req       in         req_valid/req_stall  func, bit_index, run_length
//  rsp       out        rsp_valid/rsp_stall  flag, start_index
//  csr       in         csr_wr_en            bitmap_bytes
//
// Test, set and clear take one map read; set and clear also write the word back.
// A scan reads one 64-bit word per cycle through the scan unit and ends early
// when a run is found. Reset clears the per-word valid bits at once, so there
// is no clearing pass. A new transaction is accepted once the previous result
// has moved into the response register; rsp_stall holds that register, and a
// finished result waits in DONE while it is held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_run_allocator import bra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_wr_en,
   input  logic [BYTES_W-1:0] csr_wr_data
);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [MAP_WORDS-1:0] vld_ff, vld_in;
   logic                 rd_vld_ff;
   logic [WCNT_W-1:0]    iss_ff, iss_in;
   logic                 p0_vld_ff, p0_vld_in;
   logic [WADDR_W-1:0]   p0_idx_ff;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;

   logic                 req_accept;
   logic [BYTES_W-1:0]   bytes_eff;
   logic [BYTES_W-1:0]   bytes_round;
   logic [WCNT_W-1:0]    nwords;
   logic [LEN_W-1:0]     limit;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] ram_q;
   logic [WORD_BITS-1:0] eff_word;
   logic [WORD_BITS-1:0] tail_keep;
   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [BITPOS_W-1:0]  bit_pos;
   logic                 issuing;
   scan_in_type          sin;
   scan_res_type         sres;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign bytes_eff   = (bytes_ff > BYTES_RESET) ? BYTES_RESET : bytes_ff;
   assign bytes_round = bytes_eff + BYTES_W'(7);
   assign nwords      = bytes_round[BYTES_W-1:3];
   assign limit       = {bytes_eff, 3'b000};
   assign issuing     = (state_ff == ST_SCAN) && (iss_ff < nwords);
   assign rd_addr     = (state_ff == ST_SCAN) ? iss_ff[WADDR_W-1:0]
                                              : req_payload.bit_index[UNIT_W-1:BITPOS_W];
   assign eff_word    = rd_vld_ff ? ram_q : '0;
   assign bit_pos     = req_ff.bit_index[BITPOS_W-1:0];
   assign tail_keep   = (WORD_BITS'(1) << limit[BITPOS_W-1:0]) - WORD_BITS'(1);

   bra_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Units past the configured length count as used in the last partial word.
   always_comb begin
      sin.valid = p0_vld_ff && (state_ff == ST_SCAN);
      sin.last  = ({1'b0, p0_idx_ff} == (nwords - WCNT_W'(1)));
      sin.idx   = p0_idx_ff;
      if ({1'b0, p0_idx_ff} == limit[LEN_W-1:BITPOS_W]) begin
         sin.used = eff_word | ~tail_keep;
      end else begin
         sin.used = eff_word;
      end
   end

   bra_scan_unit u_scan (
      .clock  (clock),
      .reset  (reset),
      .flush  (state_ff != ST_SCAN),
      .word_in(sin),
      .need   (req_ff.run_length),
      .result (sres)
   );

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      vld_in         = vld_ff;
      iss_in         = iss_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = req_ff.bit_index[UNIT_W-1:BITPOS_W];
      ram_wr_data    = eff_word;
      p0_vld_in      = issuing;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_payload;
               res_in = '0;
               iss_in = '0;
               case (req_payload.func)
                  FUNC_TEST, FUNC_SET, FUNC_CLEAR: begin
                     state_in = ST_ACCESS;
                  end
                  FUNC_SCAN: begin
                     if (req_payload.run_length == '0 || bytes_eff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_CLEAR_ALL: begin
                     vld_in   = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            case (req_ff.func)
               FUNC_TEST: begin
                  res_in.flag = eff_word[bit_pos];
               end
               FUNC_SET: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = eff_word | (WORD_BITS'(1) << bit_pos);
               end
               FUNC_CLEAR: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = eff_word & ~(WORD_BITS'(1) << bit_pos);
               end
               default: begin
               end
            endcase
            if (ram_wr_en) begin
               vld_in[ram_wr_addr] = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (issuing) begin
               iss_in = iss_ff + WCNT_W'(1);
            end
            if (sres.done) begin
               res_in.flag        = sres.hit;
               res_in.start_index = sres.hit ? sres.start : '0;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bytes_ff     <= BYTES_RESET;
         vld_ff       <= '0;
         p0_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         p0_vld_ff    <= p0_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bytes_ff <= csr_wr_data;
         end
      end
      req_ff         <= req_in;
      iss_ff         <= iss_in;
      p0_idx_ff      <= iss_ff[WADDR_W-1:0];
      rd_vld_ff      <= vld_ff[rd_addr];
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A word already in the scan pipeline may still finish in the first DONE cycle.
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   `ASSERT_IMPLIES(a_scan_done_in_scan, clock, reset, sres.done,
                   state_ff == ST_SCAN || state_ff == ST_DONE)
   `ASSERT_IMPLIES(a_write_only_access, clock, reset, ram_wr_en,
                   state_ff == ST_ACCESS &&
                   (req_ff.func == FUNC_SET || req_ff.func == FUNC_CLEAR))
   `ASSERT_IMPLIES(a_flag_source, clock, reset, state_ff == ST_DONE && res_ff.flag,
                   req_ff.func == FUNC_TEST || req_ff.func == FUNC_SCAN)

endmodule

FILE: bench/tb_bitmap_run_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_run_allocator
// Self-checking bench for the bitmap run allocator. A short directed table
// covers reset state, field extremes and unused codes. Random traffic follows
// over several map length settings, with idle gaps on both channels and one
// long response hold. Every response is checked against a model or table row.
// ----------------------------------------------------------------------------
module tb_bitmap_run_allocator;
   import bra_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 750;
   localparam int NUM_PHASES   = 7;
   localparam int NUM_ROWS     = 24;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 200;
   localparam int CFG_SETTLE   = 10;
   localparam int DRAIN_CYCLES = 80;
   localparam int REPORT_MAX   = 10;

   localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [2:0]        func;
      logic [UNIT_W-1:0] bit_index;
      logic [LEN_W-1:0]  run_length;
      logic              typed;
      logic              flag;
      logic [UNIT_W-1:0] start_index;
   } row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_payload;
   logic               csr_wr_en;
   logic [BYTES_W-1:0] csr_wr_data;

   // A typed-in expectation travels alongside the payload it belongs to.
   logic               req_typed;
   rsp_type            req_typed_rsp;

   bit [MAP_BYTES*8-1:0] used_units;
   logic [BYTES_W-1:0]   map_length;
   rsp_type              pending_rsps[$];

   int unsigned n_mismatch  = 0;
   int unsigned n_accepted  = 0;
   int unsigned n_checked   = 0;
   int unsigned n_scans     = 0;
   int unsigned n_scan_hits = 0;
   int unsigned n_updates   = 0;
   int unsigned n_wipes     = 0;
   int unsigned n_cycles    = 0;
   int unsigned calm_left   = 0;
   bit          hold_active = 1'b0;
   bit          hold_done   = 1'b0;

   row_type            dir_rows [NUM_ROWS];
   logic [BYTES_W-1:0] phase_bytes [NUM_PHASES];

   bitmap_run_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned search_span();
      return (map_length > MAP_BYTES) ? MAP_BYTES * 8 : map_length * 8;
   endfunction

   // Applies one request to the shadow map and returns the response it yields.
   function automatic rsp_type allocate_step(req_type r);
      rsp_type     res;
      int unsigned span, free_run, u;
      res = '0;
      case (r.func)
         FUNC_TEST: res.flag = used_units[r.bit_index];
         FUNC_SET: used_units[r.bit_index] = 1'b1;
         FUNC_CLEAR: used_units[r.bit_index] = 1'b0;
         FUNC_SCAN: begin
            span = search_span();
            free_run = 0;
            if (r.run_length != 0 && r.run_length <= span) begin
               for (u = 0; u < span && !res.flag; u++) begin
                  if (used_units[u]) begin
                     free_run = 0;
                  end else begin
                     free_run++;
                     if (free_run == r.run_length) begin
                        res.flag = 1'b1;
                        res.start_index = UNIT_W'(u + 1 - free_run);
                     end
                  end
               end
            end
         end
         FUNC_CLEAR_ALL: used_units = '0;
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned span, pick, window;
      span = search_span();
      window = (span > 200) ? 200 : span;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 25) r.func = FUNC_TEST;
      else if (pick < 55) r.func = FUNC_SET;
      else if (pick < 72) r.func = FUNC_CLEAR;
      else if (pick < 95) r.func = FUNC_SCAN;
      else if (pick < 97) r.func = FUNC_CLEAR_ALL;
      else r.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      // Many updates land low in the map so that scans meet a fragmented region.
      pick = $urandom_range(99);
      if (span != 0 && pick < 45) r.bit_index = UNIT_W'($urandom_range(window - 1));
      else if (span != 0 && pick < 75) r.bit_index = UNIT_W'($urandom_range(span - 1));
      else if (pick < 85) r.bit_index = UNIT_W'(span);
      else r.bit_index = UNIT_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) r.run_length = LEN_W'($urandom_range(4, 1));
      else if (pick < 70) r.run_length = LEN_W'($urandom_range(24, 1));
      else if (pick < 82 && span != 0) r.run_length = LEN_W'($urandom_range(span, 1));
      else if (pick < 87) r.run_length = '0;
      else if (pick < 94) r.run_length = LEN_W'(span + $urandom_range(1));
      else r.run_length = LEN_W'($urandom);
      return r;
   endfunction

   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      n_mismatch++;
      if (n_mismatch <= REPORT_MAX)
         $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer(req_type r, logic typed, rsp_type typed_rsp);
      req_valid <= 1'b1;
      req_payload <= r;
      req_typed <= typed;
      req_typed_rsp <= typed_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int unsigned pick, gap;
      gap = 0;
      if (calm_left != 0) begin
         calm_left--;
      end else if (!hold_active) begin
         pick = $urandom_range(99);
         if (pick < 4) calm_left = $urandom_range(60, 20);
         else if (pick < 40) gap = $urandom_range(3, 1);
         else if (pick < 48) gap = $urandom_range(40, 10);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // The map length may only change while nothing is in flight.
   task automatic write_length(logic [BYTES_W-1:0] value);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (CFG_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type fresh, want;
      if (!reset) begin
         if (csr_wr_en)
            map_length = csr_wr_data;
         if (req_valid && !req_stall) begin
            fresh = allocate_step(req_payload);
            if (req_payload.func == FUNC_SCAN) begin
               n_scans++;
               if (fresh.flag) n_scan_hits++;
            end else if (req_payload.func == FUNC_SET || req_payload.func == FUNC_CLEAR) begin
               n_updates++;
            end else if (req_payload.func == FUNC_CLEAR_ALL) begin
               n_wipes++;
            end
            pending_rsps.push_back(req_typed ? req_typed_rsp : fresh);
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               note_mismatch("response with no transaction pending", 0, 1);
            end else begin
               want = pending_rsps.pop_front();
               n_checked++;
               if (rsp_payload.flag !== want.flag)
                  note_mismatch("flag", want.flag, rsp_payload.flag);
               if (rsp_payload.start_index !== want.start_index)
                  note_mismatch("start_index", want.start_index, rsp_payload.start_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles >= CYCLE_LIMIT) begin
         $display("tb_bitmap_run_allocator NOT OK");
         $finish;
      end
   end

   initial begin : response_stall
      bit          stall_now;
      int unsigned left, pick;
      rsp_stall = 1'b0;
      stall_now = 1'b0;
      left = 0;
      forever begin
         @(negedge clock);
         // One long hold so that the block fills up and pushes back on requests.
         if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_active = 1'b0;
            left = 0;
         end
         if (left == 0) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               stall_now = 1'b0;
               left = $urandom_range(150, 40);
            end else if (pick < 55) begin
               stall_now = 1'b0;
               left = $urandom_range(4, 1);
            end else if (pick < 92) begin
               stall_now = 1'b1;
               left = $urandom_range(3, 1);
            end else begin
               stall_now = 1'b1;
               left = $urandom_range(40, 10);
            end
         end
         rsp_stall <= stall_now;
         left--;
      end
   end

   initial begin : stimulus
      req_type     r;
      rsp_type     typed_rsp;
      int unsigned per_phase;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      req_typed = 1'b0;
      req_typed_rsp = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      map_length = BYTES_RESET;
      used_units = '0;

      dir_rows = '{
         '{FUNC_TEST,      12'd0,    13'd1,    1'b1, 1'b0, 12'd0},
         '{FUNC_TEST,      12'd4095, 13'd1,    1'b1, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd4096, 1'b1, 1'b1, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd4097, 1'b1, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd4095, 13'd8191, 1'b1, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_SET,       12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_TEST,      12'd0,    13'd0,    1'b1, 1'b1, 12'd0},
         '{FUNC_SET,       12'd4095, 13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_TEST,      12'd4095, 13'd0,    1'b1, 1'b1, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd1,    1'b0, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd4094, 1'b0, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd4095, 1'b0, 1'b0, 12'd0},
         '{FUNC_SET,       12'd100,  13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd99,   1'b0, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd100,  1'b0, 1'b0, 12'd0},
         '{FUNC_SPARE_LO,  12'd4095, 13'd8191, 1'b1, 1'b0, 12'd0},
         '{FUNC_SPARE_MID, 12'd100,  13'd1,    1'b1, 1'b0, 12'd0},
         '{FUNC_SPARE_HI,  12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_CLEAR,     12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_TEST,      12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_CLEAR_ALL, 12'd0,    13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_TEST,      12'd4095, 13'd0,    1'b1, 1'b0, 12'd0},
         '{FUNC_SCAN,      12'd0,    13'd4096, 1'b1, 1'b1, 12'd0}
      };
      // Values above the store and zero are legal register contents too.
      phase_bytes = '{10'd1023, 10'd1, 10'd0, 10'd8, 10'd37, 10'd300, 10'd512};
      per_phase = RANDOM_ITEMS / NUM_PHASES;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (i > 0) idle_gap();
         r = '{dir_rows[i].func, dir_rows[i].bit_index, dir_rows[i].run_length};
         typed_rsp = '{dir_rows[i].flag, dir_rows[i].start_index};
         offer(r, dir_rows[i].typed, typed_rsp);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_length(phase_bytes[p]);
         for (int i = 0; i < per_phase; i++) begin
            if (i > 0) idle_gap();
            offer(random_request(), 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d transactions across %0d map lengths plus the reset length.",
               n_checked, n_accepted, NUM_PHASES);
      $display("Scans: %0d (%0d found a run), bit updates: %0d, clear-all: %0d.",
               n_scans, n_scan_hits, n_updates, n_wipes);
      if (n_mismatch > REPORT_MAX)
         $display("%0d mismatches in total.", n_mismatch);
      if (n_mismatch == 0)
         $display("tb_bitmap_run_allocator OK");
      else
         $display("tb_bitmap_run_allocator NOT OK");
      $finish;
   end

endmodule
